// File: rtl/dob_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dob_pkg
// Shared constants, types and arithmetic helpers of the per-axis
// disturbance observer.
// ----------------------------------------------------------------------------
package dob_pkg;

  localparam int NUM_AXES  = 3;
  localparam int FRAC_BITS = 16;

  localparam int AXIS_W  = 2;
  localparam int DATA_W  = 32;
  localparam int GAIN_W  = 31;
  localparam int PROD_W  = 2 * DATA_W;
  localparam int ACC_W   = DATA_W + 2;
  localparam int DIFF_W  = DATA_W + 1;
  localparam int AXIS_AW = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;
  localparam int STATE_W = 4 * DATA_W;

  localparam int NUM_REGS = 8;
  localparam int PADDR_W  = $clog2(NUM_REGS) + 2;

  // register reset values
  localparam logic [GAIN_W-1:0]        POLE_GAIN_RST  = GAIN_W'(66);
  localparam logic signed [DATA_W-1:0] DAMP_GAIN_RST  = DATA_W'(64881);
  localparam logic [GAIN_W-1:0]        STEP_TIME_RST  = GAIN_W'(655);
  localparam logic [GAIN_W-1:0]        OUT_GAIN_RST   = GAIN_W'(6554);
  localparam logic [GAIN_W-1:0]        Q_POS_GAIN_RST = GAIN_W'(6554);
  localparam logic [GAIN_W-1:0]        Q_VEL_GAIN_RST = GAIN_W'(655);
  localparam logic signed [DATA_W-1:0] LIMIT_HIGH_RST = DATA_W'(655360);
  localparam logic signed [DATA_W-1:0] LIMIT_LOW_RST  = -DATA_W'(655360);

  localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) <<< (FRAC_BITS - 1);

  localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [$clog2(NUM_REGS)-1:0] {
    REG_POLE_GAIN,
    REG_DAMP_GAIN,
    REG_STEP_TIME,
    REG_OUT_GAIN,
    REG_Q_POS_GAIN,
    REG_Q_VEL_GAIN,
    REG_LIMIT_HIGH,
    REG_LIMIT_LOW
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FIN
  } state_t;

  // multiply schedule; OP_DONE is the drain step of the last product
  typedef enum logic [3:0] {
    OP_PP_VEL,
    OP_QP_VEL,
    OP_PV_DAMP,
    OP_PV_POLE,
    OP_PV_DRIVE,
    OP_QV_POLE,
    OP_QV_DAMP,
    OP_QV_DRIVE,
    OP_YP_OUT,
    OP_YQ_POS,
    OP_YQ_VEL,
    OP_YQ_ERR,
    OP_DONE
  } op_t;

  typedef enum logic [2:0] {
    DST_PP,
    DST_QP,
    DST_PV,
    DST_QV,
    DST_YP,
    DST_YQ
  } dst_t;

  localparam int DST_N = 6;

  // saturate a wide accumulator to the data width
  function automatic logic signed [DATA_W-1:0] sat_acc(input logic signed [ACC_W-1:0] v);
    logic [ACC_W-DATA_W:0] top;
    top = v[ACC_W-1:DATA_W-1];
    if (top == '0 || top == '1) begin
      return v[DATA_W-1:0];
    end
    return v[ACC_W-1] ? DATA_MIN : DATA_MAX;
  endfunction

  // round half up, drop the fraction, saturate
  function automatic logic signed [DATA_W-1:0] qround(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] s;
    logic [PROD_W-DATA_W:0]   top;
    s   = (p + ROUND_HALF) >>> FRAC_BITS;
    top = s[PROD_W-1:DATA_W-1];
    if (top == '0 || top == '1) begin
      return s[DATA_W-1:0];
    end
    return s[PROD_W-1] ? DATA_MIN : DATA_MAX;
  endfunction

endpackage
`default_nettype wire

// File: rtl/dob_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dob_in_if
// Input channel: axis index, position error and acceleration setpoint.
// ----------------------------------------------------------------------------
interface dob_in_if
  import dob_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic [AXIS_W-1:0]        axis;
  logic signed [DATA_W-1:0] position_error;
  logic signed [DATA_W-1:0] accel_setpoint;

  modport source (output valid, output axis, output position_error,
                  output accel_setpoint, input ready);
  modport sink   (input valid, input axis, input position_error,
                  input accel_setpoint, output ready);
endinterface
`default_nettype wire

// File: rtl/dob_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dob_out_if
// Result channel: axis index, clamped disturbance estimate and clamp flag.
// ----------------------------------------------------------------------------
interface dob_out_if
  import dob_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic [AXIS_W-1:0]        axis_out;
  logic signed [DATA_W-1:0] disturbance_estimate;
  logic                     clamped;

  modport source (output valid, output axis_out, output disturbance_estimate,
                  output clamped, input ready);
  modport sink   (input valid, input axis_out, input disturbance_estimate,
                  input clamped, output ready);
endinterface
`default_nettype wire

// File: rtl/dob_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dob_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dob_ram #(
  parameter  int WIDTH = 32,
  parameter  int DEPTH = 4,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

// File: rtl/disturbance_observer_per_axis.sv
`default_nettype none
// ----------------------------------------------------------------------------
// disturbance_observer_per_axis
// Per-axis second-order disturbance observer in signed Q16.16 fixed point.
// ----------------------------------------------------------------------------
// Each input word names an axis and carries a position error and an
// acceleration setpoint; each gives exactly one result word with the
// clamped estimate yq - yp. Per axis, the setpoint filter (p) and the
// error filter (q) states live in one RAM row (128 bits), read once at
// acceptance and written back when the result is loaded. Valid bits make
// a never-written row read as zero, so no clearing pass is needed after
// reset. All twelve products go through one shared 32x32 multiplier,
// one issue per cycle, with rounding, saturation and accumulation in the
// cycle after; a product that depends on an earlier result issues only
// once that result is accumulated. An in-range word runs the multiply
// steps, a finish step and the idle state before the next acceptance;
// an out-of-range axis skips the filters and goes to the finish step.
// The finish step waits while an earlier result still sits unaccepted
// in the output register. Registers sit on an APB-style port at byte
// address 4*i and should be written only while idle.
// ----------------------------------------------------------------------------
module disturbance_observer_per_axis
  import dob_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  dob_in_if.sink             in_chan,
  dob_out_if.source          out_chan,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready
);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [GAIN_W-1:0]        pole_gain_r, step_time_r, out_gain_r;
  logic [GAIN_W-1:0]        q_pos_gain_r, q_vel_gain_r;
  logic signed [DATA_W-1:0] damp_gain_r, limit_high_r, limit_low_r;
  logic                     cfg_wr;
  cfg_reg_t                 cfg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_sel = cfg_reg_t'(paddr[PADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pole_gain_r  <= POLE_GAIN_RST;
      damp_gain_r  <= DAMP_GAIN_RST;
      step_time_r  <= STEP_TIME_RST;
      out_gain_r   <= OUT_GAIN_RST;
      q_pos_gain_r <= Q_POS_GAIN_RST;
      q_vel_gain_r <= Q_VEL_GAIN_RST;
      limit_high_r <= LIMIT_HIGH_RST;
      limit_low_r  <= LIMIT_LOW_RST;
    end else if (cfg_wr) begin
      case (cfg_sel)
        REG_POLE_GAIN:  pole_gain_r  <= pwdata[GAIN_W-1:0];
        REG_DAMP_GAIN:  damp_gain_r  <= pwdata;
        REG_STEP_TIME:  step_time_r  <= pwdata[GAIN_W-1:0];
        REG_OUT_GAIN:   out_gain_r   <= pwdata[GAIN_W-1:0];
        REG_Q_POS_GAIN: q_pos_gain_r <= pwdata[GAIN_W-1:0];
        REG_Q_VEL_GAIN: q_vel_gain_r <= pwdata[GAIN_W-1:0];
        REG_LIMIT_HIGH: limit_high_r <= pwdata;
        REG_LIMIT_LOW:  limit_low_r  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      REG_POLE_GAIN:  prdata = {1'b0, pole_gain_r};
      REG_DAMP_GAIN:  prdata = damp_gain_r;
      REG_STEP_TIME:  prdata = {1'b0, step_time_r};
      REG_OUT_GAIN:   prdata = {1'b0, out_gain_r};
      REG_Q_POS_GAIN: prdata = {1'b0, q_pos_gain_r};
      REG_Q_VEL_GAIN: prdata = {1'b0, q_vel_gain_r};
      REG_LIMIT_HIGH: prdata = limit_high_r;
      REG_LIMIT_LOW:  prdata = limit_low_r;
      default:        prdata = '0;
    endcase
  end

  // gains as signed multiplier operands
  logic signed [DATA_W-1:0] pole_s, dt_s, outg_s, qpos_s, qvel_s;
  assign pole_s = $signed({1'b0, pole_gain_r});
  assign dt_s   = $signed({1'b0, step_time_r});
  assign outg_s = $signed({1'b0, out_gain_r});
  assign qpos_s = $signed({1'b0, q_pos_gain_r});
  assign qvel_s = $signed({1'b0, q_vel_gain_r});

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  state_t state_r, state_nxt;
  op_t    step_r, step_nxt;
  logic   in_fire, in_range, fin_go;

  assign in_fire  = in_chan.valid & in_chan.ready;
  assign in_range = int'(in_chan.axis) < NUM_AXES;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= OP_PP_VEL;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    fin_go        = 1'b0;
    in_chan.ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_chan.ready = 1'b1;
        if (in_chan.valid) begin
          step_nxt  = OP_PP_VEL;
          state_nxt = in_range ? ST_RUN : ST_FIN;
        end
      end
      ST_RUN: begin
        step_nxt = op_t'(step_r + 4'd1);
        if (step_r == OP_DONE) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        // hold the finished word until the output register is free
        fin_go = ~out_chan.valid | out_chan.ready;
        if (fin_go) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------
  // Accepted word
  // ---------------------------------------------------------------------
  logic [AXIS_W-1:0]        axis_r;
  logic                     in_range_r;
  logic signed [DATA_W-1:0] err_r, acc_sp_r;
  logic [AXIS_AW-1:0]       addr_r;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      axis_r     <= in_chan.axis;
      in_range_r <= in_range;
      err_r      <= in_chan.position_error;
      acc_sp_r   <= in_chan.accel_setpoint;
    end
  end

  assign addr_r = AXIS_AW'(axis_r);

  // ---------------------------------------------------------------------
  // State RAM: {p_pos, p_vel, q_pos, q_vel} per axis
  // ---------------------------------------------------------------------
  logic [NUM_AXES-1:0]      row_vld_r;
  logic [STATE_W-1:0]       ram_rdata, ram_wdata;
  logic                     ram_we, row_vld;
  logic signed [DATA_W-1:0] sp_pos, sp_vel, er_pos, er_vel;

  assign ram_we = fin_go & in_range_r;

  dob_ram #(
    .WIDTH (STATE_W),
    .DEPTH (NUM_AXES)
  ) u_state_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (addr_r),
    .wr_data (ram_wdata),
    .rd_en   (in_fire),
    .rd_addr (AXIS_AW'(in_chan.axis)),
    .rd_data (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
    end else if (ram_we) begin
      row_vld_r[addr_r] <= 1'b1;
    end
  end

  // a row never written reads as zero
  assign row_vld = in_range_r & row_vld_r[addr_r];
  assign sp_pos  = row_vld ? ram_rdata[4*DATA_W-1:3*DATA_W] : '0;
  assign sp_vel  = row_vld ? ram_rdata[3*DATA_W-1:2*DATA_W] : '0;
  assign er_pos  = row_vld ? ram_rdata[2*DATA_W-1:DATA_W]   : '0;
  assign er_vel  = row_vld ? ram_rdata[DATA_W-1:0]          : '0;

  // ---------------------------------------------------------------------
  // Shared multiplier and accumulators
  // ---------------------------------------------------------------------
  logic signed [ACC_W-1:0]  acc_r [DST_N];
  logic signed [DATA_W-1:0] pp_sat, qp_sat, pv_sat, qv_sat;
  logic signed [DATA_W-1:0] op_a, op_b, term;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  term_ext;
  dst_t                     dst, dst_r;
  logic                     neg, neg_r, mul_vld_r;

  assign pp_sat = sat_acc(acc_r[DST_PP]);
  assign qp_sat = sat_acc(acc_r[DST_QP]);
  assign pv_sat = sat_acc(acc_r[DST_PV]);
  assign qv_sat = sat_acc(acc_r[DST_QV]);

  // issue schedule: each product is accumulated before its first user issues
  always_comb begin
    op_a = '0;
    op_b = '0;
    dst  = DST_PP;
    neg  = 1'b0;
    case (step_r)
      OP_PP_VEL:   begin op_a = sp_vel; op_b = dt_s;   dst = DST_PP; end
      OP_QP_VEL:   begin op_a = er_vel; op_b = dt_s;   dst = DST_QP; end
      OP_PV_DAMP:  begin op_a = damp_gain_r; op_b = sp_vel; dst = DST_PV; end
      OP_PV_POLE:  begin op_a = pole_s; op_b = pp_sat; dst = DST_PV; neg = 1'b1; end
      OP_PV_DRIVE: begin op_a = dt_s;   op_b = acc_sp_r; dst = DST_PV; end
      OP_QV_POLE:  begin op_a = pole_s; op_b = qp_sat; dst = DST_QV; neg = 1'b1; end
      OP_QV_DAMP:  begin op_a = damp_gain_r; op_b = er_vel; dst = DST_QV; end
      OP_QV_DRIVE: begin op_a = dt_s;   op_b = err_r;  dst = DST_QV; end
      OP_YP_OUT:   begin op_a = outg_s; op_b = pp_sat; dst = DST_YP; end
      OP_YQ_POS:   begin op_a = qpos_s; op_b = qp_sat; dst = DST_YQ; neg = 1'b1; end
      OP_YQ_VEL:   begin op_a = qvel_s; op_b = qv_sat; dst = DST_YQ; neg = 1'b1; end
      OP_YQ_ERR:   begin op_a = outg_s; op_b = err_r;  dst = DST_YQ; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_vld_r <= 1'b0;
    end else begin
      mul_vld_r <= (state_r == ST_RUN) && (step_r != OP_DONE);
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
    dst_r  <= dst;
    neg_r  <= neg;
  end

  assign term     = qround(prod_r);
  assign term_ext = ACC_W'(term);

  always_ff @(posedge clk) begin
    if (state_r == ST_RUN && step_r == OP_PP_VEL) begin
      // seed positions from the stored state, clear the rest
      acc_r[DST_PP] <= ACC_W'(sp_pos);
      acc_r[DST_QP] <= ACC_W'(er_pos);
      acc_r[DST_PV] <= '0;
      acc_r[DST_QV] <= '0;
      acc_r[DST_YP] <= '0;
      acc_r[DST_YQ] <= '0;
    end else if (mul_vld_r) begin
      acc_r[dst_r] <= acc_r[dst_r] + (neg_r ? -term_ext : term_ext);
    end
  end

  assign ram_wdata = {pp_sat, pv_sat, qp_sat, qv_sat};

  // ---------------------------------------------------------------------
  // Difference, clamp and output register
  // ---------------------------------------------------------------------
  logic signed [DIFF_W-1:0] diff, lim_hi, lim_lo, upper_cut, est;
  logic signed [DATA_W-1:0] yq_sat, yp_sat;

  assign yq_sat    = sat_acc(acc_r[DST_YQ]);
  assign yp_sat    = sat_acc(acc_r[DST_YP]);
  assign diff      = DIFF_W'(yq_sat) - DIFF_W'(yp_sat);
  assign lim_hi    = DIFF_W'(limit_high_r);
  assign lim_lo    = DIFF_W'(limit_low_r);
  // the low limit wins when the limits cross
  assign upper_cut = (diff > lim_hi) ? lim_hi : diff;
  assign est       = (upper_cut < lim_lo) ? lim_lo : upper_cut;

  logic                     out_valid_r;
  logic [AXIS_W-1:0]        out_axis_r;
  logic signed [DATA_W-1:0] out_est_r;
  logic                     out_clamped_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin_go) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      out_axis_r    <= axis_r;
      out_est_r     <= in_range_r ? est[DATA_W-1:0] : '0;
      out_clamped_r <= in_range_r & (est != diff);
    end
  end

  assign out_chan.valid                = out_valid_r;
  assign out_chan.axis_out             = out_axis_r;
  assign out_chan.disturbance_estimate = out_est_r;
  assign out_chan.clamped              = out_clamped_r;

`ifndef NO_ASSERTIONS
  // state is written back only for an axis that exists
  a_wb_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> int'(axis_r) < NUM_AXES)
    else $error("state write-back for an out-of-range axis");

  // an in-range word always starts the multiply schedule
  a_run_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_range |=> state_r == ST_RUN && step_r == OP_PP_VEL)
    else $error("accepted word did not start the schedule");

  // a new result appears only from the finish step
  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(fin_go))
    else $error("result raised without a finished word");
`endif

endmodule
`default_nettype wire

// File: tb/sv/tb_disturbance_observer_per_axis.sv
// ----------------------------------------------------------------------------
// tb_disturbance_observer_per_axis
// Self-checking bench for the per-axis disturbance observer: a directed
// stimulus table, then bursts of random words under several register
// settings. Every result word is checked against a hand-typed value or
// an in-bench fixed-point model of both per-axis filters and limit clamp.
// ----------------------------------------------------------------------------
module tb_disturbance_observer_per_axis;
  import dob_pkg::*;

  localparam int RUN_LIMIT     = 4_000_000;
  localparam int SETTLE_CYCLES = 20;
  localparam int SHOW_MAX      = 10;
  localparam int N_DIR         = 20;

  // first axis index the block does not serve
  localparam logic [AXIS_W-1:0] OFF_AXIS = AXIS_W'(NUM_AXES);

  localparam longint Q_MAX = longint'(DATA_MAX);
  localparam longint Q_MIN = longint'(DATA_MIN);

  localparam logic [DATA_W-1:0] RESET_REGS [NUM_REGS] = '{
    DATA_W'(POLE_GAIN_RST), DAMP_GAIN_RST, DATA_W'(STEP_TIME_RST),
    DATA_W'(OUT_GAIN_RST), DATA_W'(Q_POS_GAIN_RST), DATA_W'(Q_VEL_GAIN_RST),
    LIMIT_HIGH_RST, LIMIT_LOW_RST
  };

  typedef struct packed {
    logic [AXIS_W-1:0]        axis;
    logic signed [DATA_W-1:0] est;
    logic                     clamped;
  } estimate_t;

  // one row of the directed part; given marks a result typed in by hand
  typedef struct packed {
    logic [AXIS_W-1:0] axis;
    logic [DATA_W-1:0] err;
    logic [DATA_W-1:0] acc;
    logic              given;
    logic [DATA_W-1:0] est;
    logic              clamped;
  } stim_row_t;

  // Rows 1-5 have results readable at a glance: all-zero input on a fresh
  // axis gives zero, an axis out of range gives zero, and a full-scale
  // error on a fresh axis runs into the reset limits.
  stim_row_t dir_rows [N_DIR] = '{
    '{2'd0,     32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0,          1'b0},
    '{OFF_AXIS, DATA_MAX,      DATA_MIN,      1'b1, 32'h0,          1'b0},
    '{2'd1,     DATA_MAX,      32'h0000_0000, 1'b1, LIMIT_HIGH_RST, 1'b1},
    '{2'd2,     DATA_MIN,      32'h0000_0000, 1'b1, LIMIT_LOW_RST,  1'b1},
    '{OFF_AXIS, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h0,          1'b0},
    '{2'd0,     DATA_MAX,      DATA_MAX,      1'b0, 32'h0,          1'b0},
    '{2'd0,     DATA_MIN,      DATA_MIN,      1'b0, 32'h0,          1'b0},
    '{2'd0,     DATA_MAX,      DATA_MIN,      1'b0, 32'h0,          1'b0},
    '{2'd0,     DATA_MIN,      DATA_MAX,      1'b0, 32'h0,          1'b0},
    '{2'd1,     32'h5555_5555, 32'hAAAA_AAAA, 1'b0, 32'h0,          1'b0},
    '{2'd1,     32'hAAAA_AAAA, 32'h5555_5555, 1'b0, 32'h0,          1'b0},
    '{2'd2,     32'hFFFF_FFFF, 32'h0000_0001, 1'b0, 32'h0,          1'b0},
    '{2'd2,     32'h0000_0001, 32'hFFFF_FFFF, 1'b0, 32'h0,          1'b0},
    '{2'd1,     32'h0001_0000, 32'h0001_0000, 1'b0, 32'h0,          1'b0},
    '{2'd1,     32'h0001_0000, 32'h0001_0000, 1'b0, 32'h0,          1'b0},
    '{2'd1,     32'h0001_0000, 32'h0001_0000, 1'b0, 32'h0,          1'b0},
    '{2'd2,     32'hFFFF_0000, 32'h0000_8000, 1'b0, 32'h0,          1'b0},
    '{2'd2,     32'h0000_8000, 32'hFFFF_8000, 1'b0, 32'h0,          1'b0},
    '{2'd0,     32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0,          1'b0},
    '{2'd0,     32'h7FFF_0000, 32'h8001_0000, 1'b0, 32'h0,          1'b0}
  };

  logic               clk = 1'b0;
  logic               rst_n;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [DATA_W-1:0]  pwdata;
  logic [DATA_W-1:0]  prdata;
  logic               pready;

  dob_in_if  in_bus ();
  dob_out_if out_bus ();

  disturbance_observer_per_axis DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_bus),
    .out_chan (out_bus),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Observer model: shared gains, four filter states per axis
  // --------------------------------------------------------------------------
  longint k_pole, k_damp, k_dt, k_out, k_qpos, k_qvel, lim_hi, lim_lo;
  int     sp_pos [NUM_AXES];
  int     sp_vel [NUM_AXES];
  int     er_pos [NUM_AXES];
  int     er_vel [NUM_AXES];

  estimate_t pending_est [$];
  int        mismatches = 0;
  bit        steady = 1'b0;   // set for the stretch with no idling

  function automatic longint clip32(input longint v);
    if (v > Q_MAX) return Q_MAX;
    if (v < Q_MIN) return Q_MIN;
    return v;
  endfunction

  // exact product, add half an LSB, shift out the fraction, saturate
  function automatic longint fx_mul(input longint a, input longint b);
    longint p;
    p = a * b + (longint'(1) <<< (FRAC_BITS - 1));
    return clip32(p >>> FRAC_BITS);
  endfunction

  // gains other than damping are 31 bits wide and drop bit 31 of the written word
  function automatic void apply_reg(input cfg_reg_t r, input logic [DATA_W-1:0] v);
    longint g;
    longint s;
    g = longint'(v[GAIN_W-1:0]);
    s = longint'(signed'(v));
    case (r)
      REG_POLE_GAIN:  k_pole = g;
      REG_DAMP_GAIN:  k_damp = s;
      REG_STEP_TIME:  k_dt   = g;
      REG_OUT_GAIN:   k_out  = g;
      REG_Q_POS_GAIN: k_qpos = g;
      REG_Q_VEL_GAIN: k_qvel = g;
      REG_LIMIT_HIGH: lim_hi = s;
      REG_LIMIT_LOW:  lim_lo = s;
      default: ;
    endcase
  endfunction

  function automatic void reset_model();
    for (int r = 0; r < NUM_REGS; r++) apply_reg(cfg_reg_t'(r), RESET_REGS[r]);
    for (int a = 0; a < NUM_AXES; a++) begin
      sp_pos[a] = 0;
      sp_vel[a] = 0;
      er_pos[a] = 0;
      er_vel[a] = 0;
    end
  endfunction

  // Advance both filters of one axis and form the clamped estimate.
  // Position moves first, velocity then uses the new position.
  function automatic estimate_t observe(input logic [AXIS_W-1:0] ax,
                                        input int err, input int acc);
    estimate_t r;
    longint    pp, pv, qp, qv, yp, yq, diff, v;
    r.axis    = ax;
    r.est     = '0;
    r.clamped = 1'b0;
    // an axis out of range leaves every state alone and reports zero
    if (ax >= NUM_AXES) return r;
    pp = clip32(sp_pos[ax] + fx_mul(sp_vel[ax], k_dt));
    pv = clip32(-fx_mul(k_pole, pp) + fx_mul(k_damp, sp_vel[ax]) + fx_mul(k_dt, acc));
    qp = clip32(er_pos[ax] + fx_mul(k_dt, er_vel[ax]));
    qv = clip32(-fx_mul(k_pole, qp) + fx_mul(k_damp, er_vel[ax]) + fx_mul(k_dt, err));
    sp_pos[ax] = int'(pp);
    sp_vel[ax] = int'(pv);
    er_pos[ax] = int'(qp);
    er_vel[ax] = int'(qv);
    yp   = fx_mul(k_out, pp);
    yq   = clip32(-fx_mul(k_qpos, qp) - fx_mul(k_qvel, qv) + fx_mul(k_out, err));
    diff = yq - yp;
    // the low limit is applied last, so it wins when the limits cross
    v = (diff > lim_hi) ? lim_hi : diff;
    v = (v < lim_lo) ? lim_lo : v;
    r.est     = DATA_W'(v);
    r.clamped = (v != diff);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Result side: random stall bursts on ready, check each word taken
  // --------------------------------------------------------------------------
  int stall_left = 0;

  // about one cycle in a hundred starts a stall burst on ready
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
    end else if (!steady && $urandom_range(99) == 0) begin
      stall_left = $urandom_range(16, 1);
    end
    out_bus.ready <= (stall_left == 0);
  end

  task automatic flag_mismatch(input string what, input estimate_t want,
                               input estimate_t got);
    mismatches++;
    if (mismatches <= SHOW_MAX)
      $display("%s: expected axis %0d est %0d clamped %0b, got axis %0d est %0d clamped %0b",
               what, want.axis, want.est, want.clamped, got.axis, got.est, got.clamped);
  endtask

  always @(posedge clk) begin : result_check
    estimate_t got;
    estimate_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      got.axis    = out_bus.axis_out;
      got.est     = out_bus.disturbance_estimate;
      got.clamped = out_bus.clamped;
      if (pending_est.size() == 0) begin
        flag_mismatch("unexpected result word", '0, got);
      end else begin
        want = pending_est.pop_front();
        if (got.axis !== want.axis || got.est !== want.est ||
            got.clamped !== want.clamped)
          flag_mismatch("estimate mismatch", want, got);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers; every task is entered just after a rising edge
  // --------------------------------------------------------------------------

  // append the expected word for a freshly accepted input
  function automatic void queue_expected(input estimate_t e);
    pending_est = {pending_est, e};
  endfunction

  // Offer one word, hold it until taken, then log what it should produce.
  // valid is never lowered here except inside an idle gap.
  task automatic push_word(input logic [AXIS_W-1:0] ax, input logic [DATA_W-1:0] err,
                           input logic [DATA_W-1:0] acc, input logic given,
                           input estimate_t given_est);
    estimate_t want;
    if (!steady && $urandom_range(99) < 8) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(24, 1)) @(posedge clk);
    end
    in_bus.valid          <= 1'b1;
    in_bus.axis           <= ax;
    in_bus.position_error <= err;
    in_bus.accel_setpoint <= acc;
    do @(posedge clk); while (!in_bus.ready);
    want = observe(ax, err, acc);
    queue_expected(given ? given_est : want);
  endtask

  // Back-to-back APB writes: psel stays up between them and drops once at
  // the end, so no signal sees two assignments in one step.
  task automatic write_reg(input cfg_reg_t r, input logic [DATA_W-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({r, 2'b00});
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    apply_reg(r, v);
  endtask

  task automatic program_all(input logic [DATA_W-1:0] vals [NUM_REGS]);
    for (int r = 0; r < NUM_REGS; r++) write_reg(cfg_reg_t'(r), vals[r]);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // drop valid, wait for every result, then let the block settle in idle
  task automatic drain();
    in_bus.valid <= 1'b0;
    while (pending_est.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // mostly a few units either side of zero, sometimes wide or full scale
  function automatic logic [DATA_W-1:0] rand_q();
    case ($urandom_range(19))
      0:       return DATA_MAX;
      1:       return DATA_MIN;
      2, 3, 4: return $urandom;
      5, 6, 7: return $urandom_range(32'h0200_0000) - 32'h0100_0000;
      default: return $urandom_range(32'h0008_0000) - 32'h0004_0000;
    endcase
  endfunction

  // plausible gains near the reset ones, with a full-range word now and then
  function automatic logic [DATA_W-1:0] rand_reg(input cfg_reg_t r);
    if ($urandom_range(3) == 0) return $urandom;
    case (r)
      REG_DAMP_GAIN:  return $urandom_range(32'h0001_2000, 32'h0000_8000);
      REG_LIMIT_HIGH: return $urandom_range(32'h0100_0000);
      REG_LIMIT_LOW:  return 32'h0 - $urandom_range(32'h0100_0000);
      default:        return $urandom_range(32'h0002_0000);
    endcase
  endfunction

  // Bursts on one axis around a held error and setpoint, so the filters
  // settle and ring; one word in ten is plain noise.
  task automatic run_random(input int n_words);
    logic [AXIS_W-1:0] ax;
    logic [DATA_W-1:0] base_err;
    logic [DATA_W-1:0] base_acc;
    int                sent;
    int                len;
    sent = 0;
    while (sent < n_words) begin
      ax       = ($urandom_range(99) < 5) ? OFF_AXIS : AXIS_W'($urandom_range(NUM_AXES - 1));
      len      = $urandom_range(12, 1);
      base_err = rand_q();
      base_acc = rand_q();
      for (int j = 0; j < len && sent < n_words; j++) begin
        if ($urandom_range(9) == 0)
          push_word(ax, rand_q(), rand_q(), 1'b0, '0);
        else
          push_word(ax, base_err + DATA_W'($urandom_range(2047)) - DATA_W'(1024),
                    base_acc + DATA_W'($urandom_range(2047)) - DATA_W'(1024), 1'b0, '0);
        sent++;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [DATA_W-1:0] regs_v [NUM_REGS];
    estimate_t         row_est;

    reset_model();
    rst_n                 <= 1'b0;
    in_bus.valid          <= 1'b0;
    in_bus.axis           <= '0;
    in_bus.position_error <= '0;
    in_bus.accel_setpoint <= '0;
    psel                  <= 1'b0;
    penable               <= 1'b0;
    pwrite                <= 1'b0;
    paddr                 <= '0;
    pwdata                <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed table under the reset settings
    for (int i = 0; i < N_DIR; i++) begin
      row_est.axis    = dir_rows[i].axis;
      row_est.est     = dir_rows[i].est;
      row_est.clamped = dir_rows[i].clamped;
      push_word(dir_rows[i].axis, dir_rows[i].err, dir_rows[i].acc,
                dir_rows[i].given, row_est);
    end
    run_random(80);
    drain();

    // every gain at full scale, limits wide open: only saturation bites
    regs_v = '{32'h7FFF_FFFF, DATA_MAX, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
               32'h7FFF_FFFF, 32'h7FFF_FFFF, DATA_MAX, DATA_MIN};
    program_all(regs_v);
    run_random(50);
    drain();

    // gains written with only bit 31 set read as zero; damping most
    // negative; limits crossed so the low limit decides every in-range estimate
    regs_v = '{32'h8000_0000, DATA_MIN, 32'h8000_0000, 32'h8000_0000,
               32'h8000_0000, 32'h8000_0000, DATA_MIN, DATA_MAX};
    program_all(regs_v);
    run_random(50);
    drain();

    // reset gains with both limits at zero: every non-zero difference clamps to zero
    regs_v                 = RESET_REGS;
    regs_v[REG_LIMIT_HIGH] = '0;
    regs_v[REG_LIMIT_LOW]  = '0;
    program_all(regs_v);
    run_random(50);
    drain();

    repeat (3) begin
      for (int r = 0; r < NUM_REGS; r++) regs_v[r] = rand_reg(cfg_reg_t'(r));
      program_all(regs_v);
      run_random(60);
      drain();
    end

    // back to the reset settings, with neither side idling
    regs_v = RESET_REGS;
    program_all(regs_v);
    steady <= 1'b1;
    run_random(100);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // hard stop if the block hangs
  initial begin
    #(RUN_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
